/* rtl/x86_16bit_instruction_decoder_macros.svh */
// Assertion macros used by the decoder back module.
`ifndef X86_16BIT_INSTRUCTION_DECODER_MACROS_SVH
`define X86_16BIT_INSTRUCTION_DECODER_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, a, c)
`define ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

/* rtl/x86dec_pkg.sv */
package x86dec_pkg;

	localparam logic [2:0] FORM_RR  = 3'd0;
	localparam logic [2:0] FORM_RM  = 3'd1;
	localparam logic [2:0] FORM_IRM = 3'd2;
	localparam logic [2:0] FORM_IR  = 3'd3;
	localparam logic [2:0] FORM_IA  = 3'd4;
	localparam logic [2:0] FORM_JMP = 3'd5;

	localparam logic [4:0] MN_MOV = 5'd0;
	localparam logic [4:0] MN_ADD = 5'd1;
	localparam logic [4:0] MN_SUB = 5'd2;
	localparam logic [4:0] MN_CMP = 5'd3;
	localparam logic [4:0] MN_JMP0 = 5'd4;

	// Decoded word handed from the front to the back.
	typedef struct packed {
		logic        rd;
		logic [2:0]  rd_idx;
		logic        status;
		logic [2:0]  length;
		logic [4:0]  mnemonic;
		logic [2:0]  form;
		logic        to_reg;
		logic        wide;
		logic [1:0]  mod_f;
		logic [2:0]  reg_f;
		logic [2:0]  rm_f;
		logic [15:0] disp;
		logic [15:0] imm;
		logic        wr_en;
		logic        wr_copy;
		logic [2:0]  wr_dst;
		logic [2:0]  wr_src;
	} dec_t;

	// Jump opcode to mnemonic offset; 5'd31 means not a jump.
	function automatic logic [4:0] jump_index(input logic [7:0] op);
		logic [4:0] r;
		begin
			unique case (op)
				8'h74: r = 5'd0;  8'h7C: r = 5'd1;  8'h7E: r = 5'd2;  8'h72: r = 5'd3;
				8'h76: r = 5'd4;  8'h7A: r = 5'd5;  8'h70: r = 5'd6;  8'h78: r = 5'd7;
				8'h75: r = 5'd8;  8'h7D: r = 5'd9;  8'h7F: r = 5'd10; 8'h73: r = 5'd11;
				8'h77: r = 5'd12; 8'h7B: r = 5'd13; 8'h71: r = 5'd14; 8'h79: r = 5'd15;
				8'hE2: r = 5'd16; 8'hE1: r = 5'd17; 8'hE0: r = 5'd18; 8'hE3: r = 5'd19;
				default: r = 5'd31;
			endcase
			return r;
		end
	endfunction

endpackage

/* rtl/x86_16bit_instruction_decoder.sv */
// Channel | direction | handshake        | payload
// in      | input     | in_valid/stall   | op, byte0..byte5, read_index
// out     | output    | out_valid/stall  | status .. read_value
// cfg     | input     | cfg_we           | cfg_wdata (exec_enable)
// One word per cycle sustained while out_stall is low; each word passes the front register, then the back register.
// The front's skid slot lets a new word be accepted while the back is stalled.
// Register writes and reads happen in the back, one word at a time, in order.
// Reset clears control state, the register file and exec_enable.
module x86_16bit_instruction_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        op,
	input  logic [7:0]  byte0,
	input  logic [7:0]  byte1,
	input  logic [7:0]  byte2,
	input  logic [7:0]  byte3,
	input  logic [7:0]  byte4,
	input  logic [7:0]  byte5,
	input  logic [2:0]  read_index,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        status,
	output logic [2:0]  length,
	output logic [4:0]  mnemonic,
	output logic [2:0]  form,
	output logic        to_reg,
	output logic        wide,
	output logic [1:0]  mod_field,
	output logic [2:0]  reg_field,
	output logic [2:0]  rm_field,
	output logic [15:0] displacement,
	output logic [15:0] immediate,
	output logic [15:0] read_value
);
	logic exec_q;
	logic dec_valid, dec_stall;
	x86dec_pkg::dec_t dec_word;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) exec_q <= 1'b0;
		else if (cfg_we) exec_q <= cfg_wdata;
	end

	x86dec_front u_front (
		.clk, .arst_n, .in_valid, .in_stall, .op, .byte0, .byte1, .byte2, .byte3,
		.byte4, .byte5, .read_index, .exec_enable(exec_q), .dec_valid, .dec_stall,
		.dec_word
	);

	x86dec_back u_back (
		.clk, .arst_n, .dec_valid, .dec_stall, .dec_word, .out_valid, .out_stall,
		.status, .length, .mnemonic, .form, .to_reg, .wide, .mod_field, .reg_field,
		.rm_field, .displacement, .immediate, .read_value
	);
endmodule

/* rtl/x86dec_front.sv */
// Front: accepts a window, classifies it and pushes a decoded word.
module x86dec_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                op,
	input  logic [7:0]          byte0,
	input  logic [7:0]          byte1,
	input  logic [7:0]          byte2,
	input  logic [7:0]          byte3,
	input  logic [7:0]          byte4,
	input  logic [7:0]          byte5,
	input  logic [2:0]          read_index,
	input  logic                exec_enable,
	output logic                dec_valid,
	input  logic                dec_stall,
	output x86dec_pkg::dec_t    dec_word
);
	x86dec_pkg::dec_t d;
	logic [7:0] b [0:5];
	logic [5:0] hi6;
	logic [1:0] md;
	logic [2:0] rmv;
	logic [2:0] sel;
	logic [2:0] mlen;
	logic [15:0] mdisp;
	logic big;
	logic [4:0] ji;
	logic [7:0] im_lo, im_hi;

	assign b[0] = byte0;
	assign b[1] = byte1;
	assign b[2] = byte2;
	assign b[3] = byte3;
	assign b[4] = byte4;
	assign b[5] = byte5;
	assign hi6 = byte0[7:2];
	assign md = byte1[7:6];
	assign rmv = byte1[2:0];
	assign sel = byte1[5:3];
	assign ji = x86dec_pkg::jump_index(byte0);

	// Operand length and displacement of the mod/reg/rm forms.
	always_comb begin
		mlen = 3'd2;
		mdisp = 16'd0;
		if (md == 2'd1) begin
			mlen = 3'd3;
			mdisp = {8'd0, byte2};
		end else if (md == 2'd2 || (md == 2'd0 && rmv == 3'd6)) begin
			mlen = 3'd4;
			mdisp = {byte3, byte2};
		end
	end

	// Immediate bytes sit right after the operand bytes.
	always_comb begin
		im_lo = b[mlen];
		im_hi = (mlen == 3'd4) ? byte5 : b[mlen + 3'd1];
	end

	// Classification.
	always_comb begin
		d = '0;
		big = 1'b0;
		if (op) begin
			d.rd = 1'b1;
			d.rd_idx = read_index;
		end else if (hi6 == 6'h22 || hi6 == 6'h00 || hi6 == 6'h0A || hi6 == 6'h0E) begin
			d.mnemonic = (hi6 == 6'h22) ? x86dec_pkg::MN_MOV : (hi6 == 6'h00) ?
				x86dec_pkg::MN_ADD : (hi6 == 6'h0A) ? x86dec_pkg::MN_SUB : x86dec_pkg::MN_CMP;
			d.to_reg = byte0[1];
			d.wide = byte0[0];
			d.mod_f = md;
			d.reg_f = sel;
			d.rm_f = rmv;
			d.disp = (md == 2'd3) ? 16'd0 : mdisp;
			d.length = mlen;
			d.form = (md == 2'd3) ? x86dec_pkg::FORM_RR : x86dec_pkg::FORM_RM;
			if (hi6 == 6'h22 && md == 2'd3 && byte0[0] && exec_enable) begin
				d.wr_en = 1'b1;
				d.wr_copy = 1'b1;
				d.wr_dst = byte0[1] ? sel : rmv;
				d.wr_src = byte0[1] ? rmv : sel;
			end
		end else if ((byte0 & 8'hC6) == 8'h04 &&
			(hi6 == 6'h01 || hi6 == 6'h0B || hi6 == 6'h0F)) begin
			d.mnemonic = (hi6 == 6'h01) ? x86dec_pkg::MN_ADD : (hi6 == 6'h0B) ?
				x86dec_pkg::MN_SUB : x86dec_pkg::MN_CMP;
			d.form = x86dec_pkg::FORM_IA;
			d.wide = byte0[0];
			d.imm = byte0[0] ? {byte2, byte1} : {8'd0, byte1};
			d.length = byte0[0] ? 3'd3 : 3'd2;
		end else if (hi6 == 6'h20 || byte0[7:1] == 7'h63) begin
			if (hi6 == 6'h20) begin
				big = byte0[0] && !byte0[1];
				if (sel == 3'd0) d.mnemonic = x86dec_pkg::MN_ADD;
				else if (sel == 3'd5) d.mnemonic = x86dec_pkg::MN_SUB;
				else if (sel == 3'd7) d.mnemonic = x86dec_pkg::MN_CMP;
				else d.status = 1'b1;
			end else begin
				big = byte0[0];
				d.mnemonic = x86dec_pkg::MN_MOV;
			end
			d.form = x86dec_pkg::FORM_IRM;
			d.wide = byte0[0];
			d.mod_f = md;
			d.reg_f = sel;
			d.rm_f = rmv;
			d.disp = (md == 2'd3) ? 16'd0 : mdisp;
			d.imm = big ? {im_hi, im_lo} : {8'd0, im_lo};
			d.length = mlen + (big ? 3'd2 : 3'd1);
		end else if (byte0[7:4] == 4'hB) begin
			d.mnemonic = x86dec_pkg::MN_MOV;
			d.form = x86dec_pkg::FORM_IR;
			d.wide = byte0[3];
			d.reg_f = byte0[2:0];
			d.imm = byte0[3] ? {byte2, byte1} : {8'd0, byte1};
			d.length = byte0[3] ? 3'd3 : 3'd2;
			d.wr_en = byte0[3] && exec_enable;
			d.wr_dst = byte0[2:0];
		end else if (ji != 5'd31) begin
			d.mnemonic = x86dec_pkg::MN_JMP0 + ji;
			d.form = x86dec_pkg::FORM_JMP;
			d.imm = {8'd0, byte1};
			d.length = 3'd2;
		end else begin
			d.status = 1'b1;
		end
		if (d.status) begin
			d = '0;
			d.status = 1'b1;
		end
	end

	// Output register with a skid slot so acceptance does not wait on stall.
	x86dec_pkg::dec_t main_q, skid_q;
	logic main_v_q, skid_v_q;

	assign in_stall = skid_v_q;
	assign dec_valid = main_v_q;
	assign dec_word = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (!main_v_q || !dec_stall) begin
				if (skid_v_q) begin
					main_q <= skid_q;
					skid_v_q <= 1'b0;
					main_v_q <= 1'b1;
				end else begin
					main_q <= d;
					main_v_q <= in_valid;
				end
			end else if (in_valid && !skid_v_q) begin
				skid_q <= d;
				skid_v_q <= 1'b1;
			end
		end
	end
endmodule

/* rtl/x86dec_back.sv */
// Back: owns the register file, carries out writes and reads.
`include "x86_16bit_instruction_decoder_macros.svh"
module x86dec_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               dec_valid,
	output logic               dec_stall,
	input  x86dec_pkg::dec_t   dec_word,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               status,
	output logic [2:0]         length,
	output logic [4:0]         mnemonic,
	output logic [2:0]         form,
	output logic               to_reg,
	output logic               wide,
	output logic [1:0]         mod_field,
	output logic [2:0]         reg_field,
	output logic [2:0]         rm_field,
	output logic [15:0]        displacement,
	output logic [15:0]        immediate,
	output logic [15:0]        read_value
);
	logic [15:0] gpr_q [0:7];
	logic take;
	logic out_v_q;

	assign dec_stall = out_v_q && out_stall;
	assign take = dec_valid && !dec_stall;
	assign out_valid = out_v_q;

	// Register file update, applied in order as words are taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) gpr_q[i] <= 16'd0;
		end else if (take && dec_word.wr_en) begin
			gpr_q[dec_word.wr_dst] <= dec_word.wr_copy ? gpr_q[dec_word.wr_src] :
				dec_word.imm;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (!dec_stall) begin
			out_v_q <= dec_valid;
			if (dec_valid) begin
				status <= dec_word.status;
				length <= dec_word.length;
				mnemonic <= dec_word.mnemonic;
				form <= dec_word.form;
				to_reg <= dec_word.to_reg;
				wide <= dec_word.wide;
				mod_field <= dec_word.mod_f;
				reg_field <= dec_word.reg_f;
				rm_field <= dec_word.rm_f;
				displacement <= dec_word.disp;
				immediate <= dec_word.imm;
				read_value <= dec_word.rd ? gpr_q[dec_word.rd_idx] : 16'd0;
			end
		end
	end

	`ASSERT_NEXT(a_hold, clk, arst_n, out_v_q && out_stall, out_v_q)
	`ASSERT_IMPL(a_unk_len, clk, arst_n, out_v_q && status, length == 3'd0)
	`ASSERT_IMPL(a_wr_dec, clk, arst_n, take && dec_word.wr_en,
		!dec_word.rd && !dec_word.status && dec_word.wide)
endmodule
